// File: hw/rtl/tagged_min_price_select_remove_defines.svh
// Assertion macros shared by the tagged minimum-price select block.
`ifndef TAGGED_MIN_PRICE_SELECT_REMOVE_DEFINES_SVH
`define TAGGED_MIN_PRICE_SELECT_REMOVE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define TMPSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmpsr: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define TMPSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmpsr: next-cycle check failed");

`endif

// File: hw/rtl/tmpsr_pkg.sv
// Types and constants of the tagged minimum-price select block.
`timescale 1ns / 1ps

package tmpsr_pkg;

    localparam int unsigned ENTRIES    = 64;
    localparam int unsigned TAG_BITS   = 8;
    localparam int unsigned PRICE_BITS = 32;
    localparam int unsigned SLOT_BITS  = $clog2(ENTRIES);
    localparam int unsigned FILL_BITS  = SLOT_BITS + 1;
    localparam int unsigned ENTRY_BITS = PRICE_BITS + 2 * TAG_BITS;

    typedef enum logic [1:0] {
        ST_LOADED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// File: hw/rtl/tagged_min_price_select_remove.sv
// Top level of the tagged minimum-price select block: table, scan and result word.
// Usage: one input channel (i_valid / o_ready) carries a command word. A load
// word (cmd 0) appends price and two tags at the next free slot, or reports
// a full table. A query word (cmd 1) gives a tag; the block returns the
// lowest-priced valid entry whose first or second tag matches (earliest
// load on equal prices) and removes it, or reports no match.
// One result word per command leaves on the output channel (o_valid /
// i_ready) through an output register, so a finished result may wait there
// while the next command is taken in.
// Timing: a load result passes through the result register and then the
// output register. A query streams the entry RAM, one slot a cycle over all
// 64 slots, through the registered RAM read, then the result and output
// registers; the entry RAM has a single read port, so slots are read one at
// a time. One command is worked on at a time.
// Reset (synchronous, active low) empties the table: valid bits and fill
// count clear at once, RAM contents are left as they are. If the receiver
// stalls, the result word holds in the output register and a further
// finished result waits inside until the register is free.
`timescale 1ns / 1ps
`include "tagged_min_price_select_remove_defines.svh"

module tagged_min_price_select_remove
    import tmpsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [PRICE_BITS-1:0] i_entry_price,
    input  logic [TAG_BITS-1:0]   i_entry_tag_a,
    input  logic [TAG_BITS-1:0]   i_entry_tag_b,
    input  logic [TAG_BITS-1:0]   i_query_tag,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic [PRICE_BITS-1:0] o_found_price,
    output logic [SLOT_BITS-1:0]  o_found_slot
);

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(ENTRIES - 1);
    localparam logic [FILL_BITS-1:0] FULL_FILL = FILL_BITS'(ENTRIES);

    // control state
    t_state               r_state, n_state;
    logic [ENTRIES-1:0]   r_slot_valid, n_slot_valid;
    logic [FILL_BITS-1:0] r_fill, n_fill;
    logic                 r_issue, n_issue;
    logic                 r_rd_vld, n_rd_vld;
    logic                 r_hit, n_hit;
    logic                 r_out_valid, n_out_valid;

    // payload
    logic [SLOT_BITS-1:0]  r_addr, n_addr;
    logic [SLOT_BITS-1:0]  r_rd_slot, n_rd_slot;
    logic                  r_rd_sv, n_rd_sv;
    logic [TAG_BITS-1:0]   r_tag, n_tag;
    logic [PRICE_BITS-1:0] r_best_price, n_best_price;
    logic [SLOT_BITS-1:0]  r_best_slot, n_best_slot;
    t_status               r_res_status, n_res_status;
    logic [PRICE_BITS-1:0] r_res_price, n_res_price;
    logic [SLOT_BITS-1:0]  r_res_slot, n_res_slot;
    t_status               r_out_status, n_out_status;
    logic [PRICE_BITS-1:0] r_out_price, n_out_price;
    logic [SLOT_BITS-1:0]  r_out_slot, n_out_slot;

    logic                  in_acc;
    logic                  load_ok;
    logic [ENTRY_BITS-1:0] rd_data;
    logic [PRICE_BITS-1:0] rd_price;
    logic [TAG_BITS-1:0]   rd_tag_a;
    logic [TAG_BITS-1:0]   rd_tag_b;
    logic                  rd_match;
    logic                  rd_take;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign load_ok = in_acc && (t_cmd'(i_cmd) == CMD_LOAD) && (r_fill != FULL_FILL);

    // Entry RAM: {price, tag_a, tag_b} per slot; loads write, scans read.
    tmpsr_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr (r_fill[SLOT_BITS-1:0]),
        .i_wdata ({i_entry_price, i_entry_tag_a, i_entry_tag_b}),
        .i_re    (r_issue),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    assign rd_price = rd_data[ENTRY_BITS-1 -: PRICE_BITS];
    assign rd_tag_a = rd_data[2*TAG_BITS-1 -: TAG_BITS];
    assign rd_tag_b = rd_data[TAG_BITS-1:0];

    // A slot counts only if it was valid when its read was issued.
    assign rd_match = r_rd_vld && r_rd_sv && ((rd_tag_a == r_tag) || (rd_tag_b == r_tag));
    // Strictly lower price replaces the best, so the earliest slot wins ties.
    assign rd_take  = rd_match && (!r_hit || (rd_price < r_best_price));

    always_comb begin
        n_state      = r_state;
        n_slot_valid = r_slot_valid;
        n_fill       = r_fill;
        n_issue      = 1'b0;
        n_rd_vld     = r_issue;
        n_hit        = r_hit;
        n_out_valid  = r_out_valid;
        n_addr       = r_addr;
        n_rd_slot    = r_addr;
        n_rd_sv      = r_slot_valid[r_addr];
        n_tag        = r_tag;
        n_best_price = r_best_price;
        n_best_slot  = r_best_slot;
        n_res_status = r_res_status;
        n_res_price  = r_res_price;
        n_res_slot   = r_res_slot;
        n_out_status = r_out_status;
        n_out_price  = r_out_price;
        n_out_slot   = r_out_slot;

        // drop the output word once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (t_cmd'(i_cmd) == CMD_LOAD) begin
                        n_res_price = '0;
                        if (load_ok) begin
                            n_slot_valid[r_fill[SLOT_BITS-1:0]] = 1'b1;
                            n_fill       = r_fill + FILL_BITS'(1);
                            n_res_status = ST_LOADED;
                            n_res_slot   = r_fill[SLOT_BITS-1:0];
                        end else begin
                            n_res_status = ST_FULL;
                            n_res_slot   = '0;
                        end
                        n_state = S_DONE;
                    end else begin
                        // start the scan at slot zero
                        n_tag   = i_query_tag;
                        n_addr  = '0;
                        n_issue = 1'b1;
                        n_hit   = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // advance the read address until the last slot is issued
                if (r_issue) begin
                    n_issue = (r_addr != LAST_SLOT);
                    n_addr  = r_addr + SLOT_BITS'(1);
                end
                if (rd_take) begin
                    n_hit        = 1'b1;
                    n_best_price = rd_price;
                    n_best_slot  = r_rd_slot;
                end
                if (r_rd_vld && (r_rd_slot == LAST_SLOT)) begin
                    if (n_hit) begin
                        n_slot_valid[n_best_slot] = 1'b0;
                        n_res_status = ST_FOUND;
                        n_res_price  = n_best_price;
                        n_res_slot   = n_best_slot;
                    end else begin
                        n_res_status = ST_NOMATCH;
                        n_res_price  = '0;
                        n_res_slot   = '0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand over to the output register when it is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_price  = r_res_price;
                    n_out_slot   = r_res_slot;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_fill       <= '0;
            r_issue      <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_fill       <= n_fill;
            r_issue      <= n_issue;
            r_rd_vld     <= n_rd_vld;
            r_hit        <= n_hit;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_rd_slot    <= n_rd_slot;
        r_rd_sv      <= n_rd_sv;
        r_tag        <= n_tag;
        r_best_price <= n_best_price;
        r_best_slot  <= n_best_slot;
        r_res_status <= n_res_status;
        r_res_price  <= n_res_price;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_price  <= n_out_price;
        r_out_slot   <= n_out_slot;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_price = r_out_price;
    assign o_found_slot  = r_out_slot;

    `TMPSR_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FULL_FILL)
    `TMPSR_ASSERT_NEXT(a_load_marks_valid, i_clk, i_rst_n, load_ok,
        r_slot_valid[r_res_slot] && (r_res_status == ST_LOADED))
    `TMPSR_ASSERT_SAME(a_read_follows_issue, i_clk, i_rst_n, r_rd_vld && r_issue,
        r_addr == (r_rd_slot + SLOT_BITS'(1)))
    `TMPSR_ASSERT_SAME(a_found_removed, i_clk, i_rst_n,
        (r_state == S_DONE) && (r_res_status == ST_FOUND), !r_slot_valid[r_res_slot])

endmodule

// File: hw/rtl/tmpsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tmpsr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
